[src/iawr_pkg.sv]
// Package for the incast ACK window rewriter: table sizes, ethertype codes,
// register map, and the packed item, result and table-entry types.
// Used by every module of the block except iawr_ram; depends on nothing.
package iawr_pkg;

  // Port table size and derived widths
  localparam int MAX_PORTS  = 64;
  localparam int PORT_IDX_W = $clog2(MAX_PORTS);
  localparam int PORT_CNT_W = $clog2(MAX_PORTS + 1);

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Incast control ethertypes
  localparam logic [15:0] ET_ON_LOW  = 16'd31232;
  localparam logic [15:0] ET_ON_HIGH = 16'd31246;
  localparam logic [15:0] ET_OFF     = 16'd31247;

  // Register reset values
  localparam logic [15:0] BASE_WINDOW_RST = 16'd1500;
  localparam logic [15:0] TIMEOUT_MS_RST  = 16'd1000;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ENABLE      = 2'd0,
    REG_BASE_WINDOW = 2'd1,
    REG_TIMEOUT_MS  = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  // Ethertype class found by the front
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_ON    = 2'd1,
    CLS_OFF   = 2'd2
  } pkt_cls_t;

  typedef struct packed {
    logic [15:0] in_port_id;
    logic [15:0] out_port_id;
    logic [31:0] now_ms;
    logic [15:0] ether_type;
    logic        is_tcp;
    logic        ack_flag;
    logic [15:0] tcp_window;
    logic [15:0] tcp_checksum;
  } pkt_t;

  typedef struct packed {
    logic        drop;
    logic [15:0] window_out;
    logic [15:0] checksum_out;
    logic        rewritten;
    logic        table_failed;
  } res_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic [15:0] in_port_id;
    logic [15:0] out_port_id;
    logic [31:0] now_ms;
    pkt_cls_t    cls;
    logic [3:0]  shift;
    logic        ack_cand;
    logic [15:0] tcp_window;
    logic [15:0] tcp_checksum;
  } work_t;

  // Per-port incast state kept in RAM
  typedef struct packed {
    logic [31:0] start_ms;
    logic [3:0]  shift;
    logic        mark;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        enable;
    logic [15:0] base_window;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [PORT_CNT_W-1:0] entries_used;
    logic                  failed;
  } status_t;

endpackage

[src/iawr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module iawr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/iawr_front.sv]
// Front of the rewriter: accepts packet items, classifies the ethertype
// and the ACK candidacy, and queues the result for the back.
// Depends on iawr_pkg.
module iawr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            pkt_valid,
  output logic            pkt_stall,
  input  iawr_pkg::pkt_t  pkt,
  output logic            q_valid,
  input  logic            q_pop,
  output iawr_pkg::work_t q_item
);

  iawr_pkg::work_t                     queue [iawr_pkg::QUEUE_DEPTH];
  logic [iawr_pkg::QUEUE_PTR_W-1:0]    wr_ptr;
  logic [iawr_pkg::QUEUE_PTR_W-1:0]    rd_ptr;
  logic [iawr_pkg::QUEUE_CNT_W-1:0]    count;
  iawr_pkg::work_t                     cls_item;
  logic [15:0]                         et_diff;
  logic                                push;
  logic                                pop;

  // Classify the incoming packet
  always_comb begin
    et_diff               = pkt.ether_type - iawr_pkg::ET_ON_LOW;
    cls_item.in_port_id   = pkt.in_port_id;
    cls_item.out_port_id  = pkt.out_port_id;
    cls_item.now_ms       = pkt.now_ms;
    cls_item.shift        = et_diff[3:0];
    cls_item.ack_cand     = pkt.is_tcp & pkt.ack_flag;
    cls_item.tcp_window   = pkt.tcp_window;
    cls_item.tcp_checksum = pkt.tcp_checksum;
    if (pkt.ether_type inside {[iawr_pkg::ET_ON_LOW:iawr_pkg::ET_ON_HIGH]}) begin
      cls_item.cls = iawr_pkg::CLS_ON;
    end else if (pkt.ether_type == iawr_pkg::ET_OFF) begin
      cls_item.cls = iawr_pkg::CLS_OFF;
    end else begin
      cls_item.cls = iawr_pkg::CLS_OTHER;
    end
  end

  assign pkt_stall = (count == iawr_pkg::QUEUE_CNT_W'(iawr_pkg::QUEUE_DEPTH));
  assign push      = pkt_valid & ~pkt_stall;
  assign q_valid   = (count != '0);
  assign pop       = q_pop & q_valid;
  assign q_item    = queue[rd_ptr];

  // Store classified items
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls_item;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == iawr_pkg::QUEUE_PTR_W'(iawr_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == iawr_pkg::QUEUE_PTR_W'(iawr_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/iawr_back.sv]
// Back of the rewriter: port table lookup and append, incast state update
// through the entry RAM, window rewrite and checksum fixup, output register.
// Depends on iawr_pkg and iawr_ram.
module iawr_back (
  input  logic              clk,
  input  logic              rst,
  input  iawr_pkg::cfg_t    cfg,
  input  logic              q_valid,
  output logic              q_pop,
  input  iawr_pkg::work_t   q_item,
  output logic              res_valid,
  input  logic              res_stall,
  output iawr_pkg::res_t    res,
  output iawr_pkg::status_t status
);

  localparam int IW = iawr_pkg::PORT_IDX_W;
  localparam int CW = iawr_pkg::PORT_CNT_W;
  localparam int NP = iawr_pkg::MAX_PORTS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  state_t             state;
  iawr_pkg::work_t    item;
  logic [15:0]        port_ids [NP];
  logic [NP-1:0]      ent_vld;
  logic [NP-1:0]      in_hit;
  logic [NP-1:0]      out_hit;
  logic [CW-1:0]      entries_used;
  logic               failed;
  logic [IW-1:0]      j_idx;
  logic               r_drop;
  logic               r_rew;
  logic [15:0]        r_nw;

  // Lookup compare, one cell per table entry
  logic [NP-1:0]      in_hit_next;
  logic [NP-1:0]      out_hit_next;

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      in_hit_next[k]  = (CW'(k) < entries_used) && (port_ids[k] == item.in_port_id);
      out_hit_next[k] = (CW'(k) < entries_used) && (port_ids[k] == item.out_port_id);
    end
  end

  // Encode hit vectors (port ids are unique, so at most one bit is set)
  logic [IW-1:0] in_idx;
  logic [IW-1:0] out_idx;

  always_comb begin
    in_idx  = '0;
    out_idx = '0;
    for (int k = 0; k < NP; k++) begin
      if (in_hit[k]) begin
        in_idx = in_idx | IW'(k);
      end
      if (out_hit[k]) begin
        out_idx = out_idx | IW'(k);
      end
    end
  end

  // Resolve indices and appends
  logic          in_any;
  logic          out_any;
  logic          same_port;
  logic          add_in;
  logic          add_out;
  logic          fail_in;
  logic          fail_out;
  logic [CW-1:0] used_after_in;
  logic [IW-1:0] i_res;
  logic [IW-1:0] j_res;
  logic [CW-1:0] used_next;

  always_comb begin
    in_any        = |in_hit;
    out_any       = |out_hit;
    same_port     = (item.in_port_id == item.out_port_id);
    add_in        = ~in_any;
    fail_in       = add_in && (entries_used == CW'(NP));
    used_after_in = entries_used + CW'(add_in);
    add_out       = ~out_any && !(add_in && same_port) && !fail_in;
    fail_out      = add_out && (used_after_in == CW'(NP));
    i_res         = in_any ? in_idx : entries_used[IW-1:0];
    if (out_any) begin
      j_res = out_idx;
    end else if (same_port) begin
      j_res = i_res;
    end else begin
      j_res = used_after_in[IW-1:0];
    end
    if (fail_in) begin
      used_next = entries_used;
    end else if (fail_out) begin
      used_next = used_after_in;
    end else begin
      used_next = used_after_in + CW'(add_out);
    end
  end

  // Entry RAM for mark, shift and start time
  logic                      ram_we;
  iawr_pkg::entry_t          ram_wdata;
  logic [iawr_pkg::ENTRY_W-1:0] ram_rdata;

  iawr_ram #(
    .WIDTH (iawr_pkg::ENTRY_W),
    .DEPTH (NP)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (j_idx),
    .wdata (ram_wdata),
    .raddr (j_res),
    .rdata (ram_rdata)
  );

  // Expire, apply the control frame or pick the rewrite
  iawr_pkg::entry_t ent;
  logic [31:0]      age;
  logic             exec_drop;
  logic             exec_rew;

  always_comb begin
    ent       = ent_vld[j_idx] ? iawr_pkg::entry_t'(ram_rdata) : '0;
    age       = item.now_ms - ent.start_ms;
    ram_wdata = ent;
    if (age >= {16'd0, cfg.timeout_ms}) begin
      ram_wdata.mark     = 1'b0;
      ram_wdata.start_ms = '0;
    end
    exec_drop = 1'b0;
    exec_rew  = 1'b0;
    case (item.cls)
      iawr_pkg::CLS_ON: begin
        if (!ram_wdata.mark) begin
          ram_wdata.start_ms = item.now_ms;
        end
        ram_wdata.mark  = 1'b1;
        ram_wdata.shift = item.shift;
        exec_drop       = 1'b1;
      end
      iawr_pkg::CLS_OFF: begin
        ram_wdata.mark     = 1'b0;
        ram_wdata.start_ms = '0;
        exec_drop          = 1'b1;
      end
      default: begin
        exec_rew = item.ack_cand & ram_wdata.mark;
      end
    endcase
    ram_we = (state == ST_EXEC);
  end

  // One's complement checksum fixup: ~(~HC + ~m + m')
  logic [17:0] cs_sum;
  logic [16:0] cs_f1;
  logic [16:0] cs_f2;
  logic [15:0] cs_new;
  logic        out_free;

  always_comb begin
    cs_sum = {2'b00, ~item.tcp_checksum} + {2'b00, ~item.tcp_window} + {2'b00, r_nw};
    cs_f1  = {1'b0, cs_sum[15:0]} + {15'd0, cs_sum[17:16]};
    cs_f2  = {1'b0, cs_f1[15:0]} + {16'd0, cs_f1[16]};
    cs_new = ~cs_f2[15:0];
  end

  assign out_free = ~res_valid | ~res_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign status   = '{entries_used: entries_used, failed: failed};

  // Sequencer, table and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ent_vld      <= '0;
      entries_used <= '0;
      failed       <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      // Drop a taken result unless the finish step loads the next one
      if (res_valid && !res_stall && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            item   <= q_item;
            r_drop <= 1'b0;
            r_rew  <= 1'b0;
            state  <= (cfg.enable && !failed) ? ST_MATCH : ST_FINISH;
          end
        end
        ST_MATCH: begin
          in_hit  <= in_hit_next;
          out_hit <= out_hit_next;
          state   <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          if (add_in && !fail_in) begin
            port_ids[entries_used[IW-1:0]] <= item.in_port_id;
          end
          if (add_out && !fail_out) begin
            port_ids[used_after_in[IW-1:0]] <= item.out_port_id;
          end
          entries_used <= used_next;
          j_idx        <= j_res;
          if (fail_in || fail_out) begin
            failed <= 1'b1;
            state  <= ST_FINISH;
          end else begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          ent_vld[j_idx] <= 1'b1;
          r_drop         <= exec_drop;
          r_rew          <= exec_rew;
          r_nw           <= cfg.base_window >> ram_wdata.shift;
          state          <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            res_valid        <= 1'b1;
            res.drop         <= r_drop;
            res.rewritten    <= r_rew;
            res.table_failed <= failed;
            if (r_drop) begin
              res.window_out   <= '0;
              res.checksum_out <= '0;
            end else if (r_rew) begin
              res.window_out   <= r_nw;
              res.checksum_out <= cs_new;
            end else begin
              res.window_out   <= item.tcp_window;
              res.checksum_out <= item.tcp_checksum;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/incast_ack_window_rewriter.sv]
// Incast ACK window rewriter, top level: register block, front and back.
// Each accepted packet passes the front queue, then the back's match, resolve,
//   entry-RAM read-modify-write and finish steps (only the finish step when
//   disabled or after a table failure); a stalled result holds the back.
// The back takes a new packet only after it has loaded the last result.
// Reset (rst, synchronous): empties the port table and queue, clears all
//   incast marks and the failure flag, loads register reset values.
module incast_ack_window_rewriter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pkt_valid,
  output logic                              pkt_stall,
  input  iawr_pkg::pkt_t                    pkt,
  output logic                              res_valid,
  input  logic                              res_stall,
  output iawr_pkg::res_t                    res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [iawr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [iawr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [iawr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  iawr_pkg::cfg_t    cfg;
  iawr_pkg::reg_idx_t reg_idx;
  iawr_pkg::work_t   q_item;
  iawr_pkg::status_t status;
  logic              q_valid;
  logic              q_pop;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = iawr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable      <= 1'b0;
      cfg.base_window <= iawr_pkg::BASE_WINDOW_RST;
      cfg.timeout_ms  <= iawr_pkg::TIMEOUT_MS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        iawr_pkg::REG_ENABLE:      cfg.enable      <= pwdata[0];
        iawr_pkg::REG_BASE_WINDOW: cfg.base_window <= pwdata[15:0];
        iawr_pkg::REG_TIMEOUT_MS:  cfg.timeout_ms  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      iawr_pkg::REG_ENABLE:      prdata = {31'd0, cfg.enable};
      iawr_pkg::REG_BASE_WINDOW: prdata = {16'd0, cfg.base_window};
      iawr_pkg::REG_TIMEOUT_MS:  prdata = {16'd0, cfg.timeout_ms};
      default:                   prdata = '0;
    endcase
  end

  iawr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  iawr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .status    (status)
  );

  // Dropped control frames carry zeroed fields and are never rewritten
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.drop |->
      res.window_out == 16'd0 && res.checksum_out == 16'd0 && !res.rewritten)
    else $error("dropped frame carries payload or rewrite");

  // A rewrite never happens once the table has failed
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rewritten |-> !res.drop && !res.table_failed)
    else $error("rewrite on dropped frame or after table failure");

  // Table fill stays within its size
  assert property (@(posedge clk) disable iff (rst)
    status.entries_used <= iawr_pkg::PORT_CNT_W'(iawr_pkg::MAX_PORTS))
    else $error("port table over-filled");

  // Failure is sticky until reset
  assert property (@(posedge clk) disable iff (rst)
    status.failed |=> status.failed)
    else $error("table failure flag cleared without reset");

endmodule
